/* sv/hsvr_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package hsvr_pkg;

  localparam int unsigned HUE_SECTOR = 3840;
  localparam logic [14:0] HUE_FULL   = 15'd23040;
  localparam logic [8:0]  UNIT       = 9'd256;
  // floor(q/15) == ((q+1)*RECIP15) >> 16 for q < 4096
  localparam logic [12:0] RECIP15    = 13'd4369;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } hsvr_sector_e;

  typedef struct packed {
    logic [14:0] hue;
    logic [8:0]  saturation;
    logic [8:0]  brightness;
  } hsvr_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsvr_out_t;

  // after sector split
  typedef struct packed {
    hsvr_sector_e sector;
    logic [11:0]  f;
    logic [8:0]   sat;
    logic [8:0]   inv_s;
    logic [15:0]  p;      // 255 * V
  } hsvr_sec_t;

  // after mix products, before divide by 15
  typedef struct packed {
    hsvr_sector_e sector;
    logic [7:0]   full;
    logic [7:0]   low;
    logic [11:0]  q_up;
    logic [11:0]  q_dn;
  } hsvr_mix_t;

endpackage

/* sv/hsvr_front.sv */
// Front stages: hue wrap and clamping, then sector split and 255*V.
// Depends on hsvr_pkg.
`timescale 1ns / 1ps
module hsvr_front
  import hsvr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  hsvr_in_t  data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output hsvr_sec_t data_o
);

  logic        a_vld_q;
  logic [14:0] a_hue_q, a_hue_d;
  logic [8:0]  a_sat_q, a_sat_d;
  logic [8:0]  a_val_q, a_val_d;
  logic        a_en, b_en;

  logic        b_vld_q;
  hsvr_sec_t   b_q, b_d;
  logic [14:0] base;
  logic [16:0] p_wide;

  assign b_en    = !b_vld_q || !stall_i;
  assign a_en    = !a_vld_q || b_en;
  assign stall_o = !a_en;
  assign valid_o = b_vld_q;
  assign data_o  = b_q;

  always_comb begin
    a_hue_d = (data_i.hue >= HUE_FULL) ? 15'(data_i.hue - HUE_FULL) : data_i.hue;
    a_sat_d = (data_i.saturation > UNIT) ? UNIT : data_i.saturation;
    a_val_d = (data_i.brightness > UNIT) ? UNIT : data_i.brightness;
  end

  always_comb begin
    if (a_hue_q >= 15'(5 * HUE_SECTOR)) begin
      b_d.sector = SEC_MAG_RED;
      base       = 15'(5 * HUE_SECTOR);
    end else if (a_hue_q >= 15'(4 * HUE_SECTOR)) begin
      b_d.sector = SEC_BLU_MAG;
      base       = 15'(4 * HUE_SECTOR);
    end else if (a_hue_q >= 15'(3 * HUE_SECTOR)) begin
      b_d.sector = SEC_CYN_BLU;
      base       = 15'(3 * HUE_SECTOR);
    end else if (a_hue_q >= 15'(2 * HUE_SECTOR)) begin
      b_d.sector = SEC_GRN_CYN;
      base       = 15'(2 * HUE_SECTOR);
    end else if (a_hue_q >= 15'(HUE_SECTOR)) begin
      b_d.sector = SEC_YEL_GRN;
      base       = 15'(HUE_SECTOR);
    end else begin
      b_d.sector = SEC_RED_YEL;
      base       = 15'd0;
    end
    b_d.f     = 12'(a_hue_q - base);
    b_d.sat   = a_sat_q;
    b_d.inv_s = 9'(UNIT - a_sat_q);
    p_wide    = {a_val_q, 8'b0} - {8'b0, a_val_q};
    b_d.p     = p_wide[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_en) a_vld_q <= valid_i;
      if (b_en) b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && valid_i) begin
      a_hue_q <= a_hue_d;
      a_sat_q <= a_sat_d;
      a_val_q <= a_val_d;
    end
    if (b_en && a_vld_q) b_q <= b_d;
  end

endmodule

/* sv/hsvr_mix.sv */
// Mix stages: blend weights, full/low levels, then the V-scaled mix products.
// Depends on hsvr_pkg.
`timescale 1ns / 1ps
module hsvr_mix
  import hsvr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  hsvr_sec_t data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output hsvr_mix_t data_o
);

  // T(w) = 3840*inv_s + w*S, at most 3840*256
  logic         c_vld_q;
  hsvr_sector_e c_sector_q;
  logic [7:0]   c_full_q, c_low_q;
  logic [15:0]  c_p_q;
  logic [19:0]  c_tup_q, c_tdn_q, c_tup_d, c_tdn_d;
  logic [7:0]   c_low_d;
  logic [19:0]  t_base;
  logic [11:0]  f_dn;
  logic [20:0]  prod_up, prod_dn;
  logic [24:0]  low_prod;
  logic         c_en, d_en;

  logic         d_vld_q;
  hsvr_mix_t    d_q, d_d;
  logic [35:0]  x_up, x_dn;

  assign d_en    = !d_vld_q || !stall_i;
  assign c_en    = !c_vld_q || d_en;
  assign stall_o = !c_en;
  assign valid_o = d_vld_q;
  assign data_o  = d_q;

  always_comb begin
    t_base   = 20'(data_i.inv_s) * 20'(HUE_SECTOR);
    f_dn     = 12'(12'(HUE_SECTOR) - data_i.f);
    prod_up  = 21'(data_i.f) * 21'(data_i.sat);
    prod_dn  = 21'(f_dn) * 21'(data_i.sat);
    c_tup_d  = 20'(21'(t_base) + prod_up);
    c_tdn_d  = 20'(21'(t_base) + prod_dn);
    low_prod = 25'(data_i.p) * 25'(data_i.inv_s);
    c_low_d  = low_prod[23:16];
  end

  always_comb begin
    x_up       = 36'(c_p_q) * 36'(c_tup_q);
    x_dn       = 36'(c_p_q) * 36'(c_tdn_q);
    d_d.sector = c_sector_q;
    d_d.full   = c_full_q;
    d_d.low    = c_low_q;
    d_d.q_up   = x_up[35:24];
    d_d.q_dn   = x_dn[35:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (c_en) c_vld_q <= valid_i;
      if (d_en) d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en && valid_i) begin
      c_sector_q <= data_i.sector;
      c_full_q   <= data_i.p[15:8];
      c_low_q    <= c_low_d;
      c_p_q      <= data_i.p;
      c_tup_q    <= c_tup_d;
      c_tdn_q    <= c_tdn_d;
    end
    if (d_en && c_vld_q) d_q <= d_d;
  end

endmodule

/* sv/hsvr_out.sv */
// Output stage: divide the mix levels by 15 and route channels by sector.
// Depends on hsvr_pkg; holds the result register.
`timescale 1ns / 1ps
module hsvr_out
  import hsvr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  hsvr_mix_t data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output hsvr_out_t data_o
);

  logic        e_vld_q;
  hsvr_out_t   e_q, e_d;
  logic        e_en;
  logic [25:0] r_up, r_dn;
  logic [7:0]  up, dn;

  assign e_en    = !e_vld_q || !stall_i;
  assign stall_o = !e_en;
  assign valid_o = e_vld_q;
  assign data_o  = e_q;

  always_comb begin
    r_up = 26'(13'(data_i.q_up) + 13'd1) * 26'(RECIP15);
    r_dn = 26'(13'(data_i.q_dn) + 13'd1) * 26'(RECIP15);
    up   = r_up[23:16];
    dn   = r_dn[23:16];
    case (data_i.sector)
      SEC_RED_YEL: e_d = '{red: data_i.full, green: up,          blue: data_i.low};
      SEC_YEL_GRN: e_d = '{red: dn,          green: data_i.full, blue: data_i.low};
      SEC_GRN_CYN: e_d = '{red: data_i.low,  green: data_i.full, blue: up};
      SEC_CYN_BLU: e_d = '{red: data_i.low,  green: dn,          blue: data_i.full};
      SEC_BLU_MAG: e_d = '{red: up,          green: data_i.low,  blue: data_i.full};
      default:     e_d = '{red: data_i.full, green: data_i.low,  blue: dn};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (e_en) begin
      e_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_en && valid_i) e_q <= e_d;
  end

endmodule

/* sv/hue_sat_value_to_rgb_top.sv */
// Top level of the HSV to RGB converter: front, mix and output stages.
// Depends on hsvr_pkg, hsvr_front, hsvr_mix, hsvr_out.
//
//   channel  dir  handshake                    payload
//   in       in   in_valid_i / in_stall_o      in_data_i  (hsvr_in_t)
//   out      out  out_valid_o / out_stall_i    out_data_o (hsvr_out_t)
//
// Five register stages, one transfer per clock while the output is not stalled.
// Stage depth is set by the 16x20 mix multiply and the divide-by-15 multiply.
// Reset clears only the stage valid bits.
// Each stage holds when it is full and the next one stalls, so bubbles close up.
`timescale 1ns / 1ps
module hue_sat_value_to_rgb_top
  import hsvr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hsvr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hsvr_out_t out_data_o
);

  logic      sec_valid, sec_stall;
  hsvr_sec_t sec_data;
  logic      mix_valid, mix_stall;
  hsvr_mix_t mix_data;

  hsvr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (sec_valid),
    .stall_i (sec_stall),
    .data_o  (sec_data)
  );

  hsvr_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sec_valid),
    .stall_o (sec_stall),
    .data_i  (sec_data),
    .valid_o (mix_valid),
    .stall_i (mix_stall),
    .data_o  (mix_data)
  );

  hsvr_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .stall_o (mix_stall),
    .data_i  (mix_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  a_no_stall_free_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  a_stall_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stall without held output");

  a_mid_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_stall |-> (out_valid_o && out_stall_i))
    else $error("output stage stalled without held output");

endmodule

/* test/tb.sv */
// Self-checking testbench for hue_sat_value_to_rgb_top: directed and random pixels,
// each predicted in the bench and compared channel by channel with the DUT output.
// Depends on hsvr_pkg and the RTL of the converter.
`timescale 1ns / 1ps
module tb;
  import hsvr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  hsvr_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  hsvr_out_t out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  hsvr_out_t   expected_rgb[$];

  hue_sat_value_to_rgb_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned mix_channel(longint unsigned val, longint unsigned inv_s,
                                                  longint unsigned w);
    longint unsigned num;
    num = 255 * val * (w * 256 + (3840 - w) * inv_s);
    return num / (64'd3840 * 64'd65536);
  endfunction

  function automatic hsvr_out_t predict_rgb(hsvr_in_t px);
    longint unsigned hue, sat, val, inv_s, f, full, low, up, down;
    hsvr_out_t       rgb;
    hue = px.hue;
    sat = px.saturation;
    val = px.brightness;
    if (hue >= HUE_FULL) hue = hue - HUE_FULL;
    if (sat > UNIT) sat = UNIT;
    if (val > UNIT) val = UNIT;
    inv_s = 256 - sat;
    f     = hue % HUE_SECTOR;
    full  = (255 * val) / 256;
    low   = (255 * val * inv_s) / 65536;
    up    = mix_channel(val, inv_s, f);
    down  = mix_channel(val, inv_s, HUE_SECTOR - f);
    case (hsvr_sector_e'(hue / HUE_SECTOR))
      SEC_RED_YEL: rgb = '{full[7:0], up[7:0], low[7:0]};
      SEC_YEL_GRN: rgb = '{down[7:0], full[7:0], low[7:0]};
      SEC_GRN_CYN: rgb = '{low[7:0], full[7:0], up[7:0]};
      SEC_CYN_BLU: rgb = '{low[7:0], down[7:0], full[7:0]};
      SEC_BLU_MAG: rgb = '{up[7:0], low[7:0], full[7:0]};
      default:     rgb = '{full[7:0], low[7:0], down[7:0]};
    endcase
    return rgb;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_pixel(input hsvr_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= hsvr_in_t'({$urandom, 1'b0});
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    expected_rgb.push_back(predict_rgb(px));
  endtask

  function automatic logic [8:0] rand_level();
    case ($urandom_range(9))
      0:       return 9'($urandom_range(511));
      1:       return $urandom_range(1) ? 9'd0 : 9'd256;
      default: return 9'($urandom_range(256));
    endcase
  endfunction

  function automatic hsvr_in_t rand_pixel();
    hsvr_in_t    px;
    int unsigned base;
    base = $urandom_range(5) * HUE_SECTOR;
    case ($urandom_range(9))
      7:       px.hue = 15'($urandom_range(1) ? base + $urandom_range(3)
                                              : base + HUE_SECTOR - 1 - $urandom_range(3));
      8, 9:    px.hue = 15'($urandom_range(32767));
      default: px.hue = 15'($urandom_range(23039));
    endcase
    px.saturation = rand_level();
    px.brightness = rand_level();
    return px;
  endfunction

  task automatic test_sector_corners();
    send_pixel('{15'd0,     9'd256, 9'd256});
    send_pixel('{15'd3839,  9'd256, 9'd256});
    send_pixel('{15'd3840,  9'd256, 9'd256});
    send_pixel('{15'd7679,  9'd256, 9'd256});
    send_pixel('{15'd7680,  9'd256, 9'd256});
    send_pixel('{15'd11520, 9'd256, 9'd256});
    send_pixel('{15'd15360, 9'd256, 9'd256});
    send_pixel('{15'd19200, 9'd256, 9'd256});
    send_pixel('{15'd23039, 9'd256, 9'd256});
    send_pixel('{15'd1920,  9'd0,   9'd256});
    send_pixel('{15'd12345, 9'd128, 9'd0});
    send_pixel('{15'd5000,  9'd256, 9'd1});
  endtask

  // out-of-range hue wraps, saturation and brightness clamp to 1.0
  task automatic test_clamped_inputs();
    send_pixel('{15'd23040, 9'd200, 9'd200});
    send_pixel('{15'd26880, 9'd100, 9'd256});
    send_pixel('{15'd32767, 9'd64,  9'd128});
    send_pixel('{15'd9000,  9'd257, 9'd180});
    send_pixel('{15'd17000, 9'd511, 9'd256});
    send_pixel('{15'd2000,  9'd50,  9'd257});
    send_pixel('{15'd21000, 9'd90,  9'd511});
    send_pixel('{15'd32767, 9'd511, 9'd511});
    send_pixel('{15'd0,     9'd0,   9'd0});
  endtask

  task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pixel(rand_pixel());
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    hsvr_out_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_rgb.size());
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_rgb.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual r=%0d g=%0d b=%0d",
                 $time, out_data.red, out_data.green, out_data.blue);
        mismatch_count <= mismatch_count + 1;
      end else begin
        want = expected_rgb.pop_front();
        if (out_data.red !== want.red || out_data.green !== want.green ||
            out_data.blue !== want.blue) begin
          $display("%0t: mismatch, expected r=%0d g=%0d b=%0d, actual r=%0d g=%0d b=%0d",
                   $time, want.red, want.green, want.blue,
                   out_data.red, out_data.green, out_data.blue);
          mismatch_count <= mismatch_count + 1;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_sector_corners();
    test_clamped_inputs();
    test_random_stream(36, 88, 630);
    test_random_stream(88, 36, 630);
    test_random_stream(0, 0, 630);
    in_valid <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
